// ===== src/knd_pkg.sv =====
// Shared types, constants and lookup functions for the keypad number entry block.
// Used by the interfaces, the keypad scanner, the display driver and the top level.
`timescale 1ns / 1ps

package knd_pkg;

    localparam int KEY_ROWS    = 4;
    localparam int KEY_COLS    = 4;
    localparam int KEY_COUNT   = KEY_ROWS * KEY_COLS;
    localparam int DIGIT_COUNT = 3;

    localparam int KEY_IDX_W = $clog2(KEY_COUNT);
    localparam int CODE_W    = 4;
    localparam int BCD_W     = 4;
    localparam int VALUE_W   = 10;
    localparam int SEG_W     = 8;
    localparam int POS_W     = 2;

    localparam logic [CODE_W-1:0]  CODE_CLEAR    = 4'd12;
    localparam logic [CODE_W-1:0]  CODE_LAST_DIG = 4'd9;
    localparam logic [SEG_W-1:0]   SEG_BLANK     = 8'hFF;
    localparam logic [BCD_W-1:0]   BCD_ZERO      = 4'd0;

    localparam logic [POS_W-1:0] POS_UNITS    = 2'd1;
    localparam logic [POS_W-1:0] POS_TENS     = 2'd2;
    localparam logic [POS_W-1:0] POS_HUNDREDS = 2'd3;

    localparam logic [DIGIT_COUNT-1:0] SEL_UNITS    = 3'b110;
    localparam logic [DIGIT_COUNT-1:0] SEL_TENS     = 3'b101;
    localparam logic [DIGIT_COUNT-1:0] SEL_HUNDREDS = 3'b011;

    typedef struct packed {
        logic                seen;
        logic [CODE_W-1:0]   code;
    } key_pick_t;

    typedef struct packed {
        logic [DIGIT_COUNT-1:0] select;
        logic [SEG_W-1:0]       segment;
    } disp_drive_t;

    typedef struct packed {
        logic [BCD_W-1:0] hundreds;
        logic [BCD_W-1:0] tens;
        logic [BCD_W-1:0] units;
    } bcd_value_t;

    // Key codes in row-major order: 1 2 3 A / 4 5 6 B / 7 8 9 C / star 0 hash D.
    function automatic logic [CODE_W-1:0] key_code_of(input logic [KEY_IDX_W-1:0] idx);
        logic [CODE_W-1:0] code;
        begin
            case (idx)
                4'd0:    code = 4'd1;
                4'd1:    code = 4'd2;
                4'd2:    code = 4'd3;
                4'd3:    code = 4'd10;
                4'd4:    code = 4'd4;
                4'd5:    code = 4'd5;
                4'd6:    code = 4'd6;
                4'd7:    code = 4'd11;
                4'd8:    code = 4'd7;
                4'd9:    code = 4'd8;
                4'd10:   code = 4'd9;
                4'd11:   code = 4'd12;
                4'd12:   code = 4'd14;
                4'd13:   code = 4'd0;
                4'd14:   code = 4'd15;
                4'd15:   code = 4'd13;
                default: code = 4'd15;
            endcase
            return code;
        end
    endfunction

    // Active-low segment byte for a decimal digit.
    function automatic logic [SEG_W-1:0] seg_of(input logic [BCD_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        begin
            case (digit)
                4'd0:    seg = 8'hC0;
                4'd1:    seg = 8'hF9;
                4'd2:    seg = 8'hA4;
                4'd3:    seg = 8'hB0;
                4'd4:    seg = 8'h99;
                4'd5:    seg = 8'h92;
                4'd6:    seg = 8'h83;
                4'd7:    seg = 8'hF8;
                4'd8:    seg = 8'h80;
                4'd9:    seg = 8'h90;
                default: seg = SEG_BLANK;
            endcase
            return seg;
        end
    endfunction

endpackage

// ===== src/knd_key_if.sv =====
// Valid/ready channel that carries one keypad snapshot per item.
// Depends on knd_pkg for the key count.
`timescale 1ns / 1ps

interface knd_key_if;
    logic                          valid;
    logic                          ready;
    logic [knd_pkg::KEY_COUNT-1:0] key_matrix;

    modport source (output valid, output key_matrix, input ready);
    modport sink   (input valid, input key_matrix, output ready);
endinterface

// ===== src/knd_result_if.sv =====
// Valid/ready channel that carries one display and key result per item.
// Depends on knd_pkg for the field widths.
`timescale 1ns / 1ps

interface knd_result_if;
    logic                            valid;
    logic                            ready;
    logic [knd_pkg::DIGIT_COUNT-1:0] digit_select;
    logic [knd_pkg::SEG_W-1:0]       segment_pattern;
    logic                            key_seen;
    logic [knd_pkg::CODE_W-1:0]      key_code;
    logic [knd_pkg::VALUE_W-1:0]     shown_value;

    modport source (output valid, output digit_select, output segment_pattern,
                    output key_seen, output key_code, output shown_value, input ready);
    modport sink   (input valid, input digit_select, input segment_pattern,
                    input key_seen, input key_code, input shown_value, output ready);
endinterface

// ===== src/keypad_number_entry_display.sv =====
// Top level of the keypad number entry block with multiplexed digit display.
// Depends on knd_pkg, knd_key_if, knd_result_if, knd_keyscan and knd_display.
`timescale 1ns / 1ps

// Usage
// The keys channel takes one 16-bit keypad snapshot per item, one per refresh tick.
// The result channel returns one item for each snapshot: the active-low digit enable
// and segment byte for the digit driven this tick, whether a newly pressed key was
// taken, its code, and the entered value after that key.
// A snapshot is registered on acceptance in the input register and handled once the
// result register is free, when the key edges, the display digit and the new value are
// all written to the result register. One item is accepted every cycle while the
// receiver keeps taking results.
// When the receiver stalls, the result register holds its item and one further
// snapshot waits in the input register; after that the keys channel stops.
// Reset marks every key released, clears the value and selects the units digit.

module keypad_number_entry_display
(
    input  logic             clk,
    input  logic             rst_n,
    knd_key_if.sink          keys,
    knd_result_if.source     result
);

    logic                          in_valid_reg;
    logic [knd_pkg::KEY_COUNT-1:0] in_keys_reg;
    logic                          step;

    logic [knd_pkg::KEY_COUNT-1:0] released_reg;
    logic [knd_pkg::KEY_COUNT-1:0] released_next;
    knd_pkg::bcd_value_t           value_reg;
    knd_pkg::bcd_value_t           value_next;
    logic [knd_pkg::VALUE_W-1:0]   bin_reg;
    logic [knd_pkg::VALUE_W-1:0]   bin_next;
    logic [knd_pkg::POS_W-1:0]     pos_reg;
    logic [knd_pkg::POS_W-1:0]     pos_clean;
    logic [knd_pkg::POS_W-1:0]     pos_next;

    knd_pkg::key_pick_t            pick;
    knd_pkg::disp_drive_t          drive;

    logic                          out_valid_reg;
    knd_pkg::disp_drive_t          out_drive_reg;
    knd_pkg::key_pick_t            out_pick_reg;
    logic [knd_pkg::VALUE_W-1:0]   out_value_reg;

    assign step       = in_valid_reg && (!out_valid_reg || result.ready);
    assign keys.ready = !in_valid_reg || step;

    assign pos_clean = (pos_reg == knd_pkg::POS_TENS || pos_reg == knd_pkg::POS_HUNDREDS)
                       ? pos_reg : knd_pkg::POS_UNITS;
    assign pos_next  = (pos_clean == knd_pkg::POS_HUNDREDS) ? knd_pkg::POS_UNITS
                       : pos_clean + 2'd1;

    knd_keyscan u_keyscan
    (
        .key_matrix    (in_keys_reg),
        .released      (released_reg),
        .released_next (released_next),
        .pick          (pick)
    );

    knd_display u_display
    (
        .position (pos_clean),
        .value    (value_reg),
        .drive    (drive)
    );

    // Digits are appended only below one hundred, so the hundreds digit is zero then.
    always_comb
    begin
        value_next = value_reg;
        bin_next   = bin_reg;
        if (pick.seen)
        begin
            if (pick.code == knd_pkg::CODE_CLEAR)
            begin
                value_next = '0;
                bin_next   = '0;
            end
            else if (value_reg.hundreds == knd_pkg::BCD_ZERO
                     && pick.code <= knd_pkg::CODE_LAST_DIG)
            begin
                value_next.hundreds = value_reg.tens;
                value_next.tens     = value_reg.units;
                value_next.units    = pick.code;
                bin_next = (bin_reg << 3) + (bin_reg << 1)
                           + knd_pkg::VALUE_W'(pick.code);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            released_reg  <= '1;
            value_reg     <= '0;
            bin_reg       <= '0;
            pos_reg       <= knd_pkg::POS_UNITS;
        end
        else
        begin
            if (keys.ready)
            begin
                in_valid_reg <= keys.valid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
                released_reg  <= released_next;
                value_reg     <= value_next;
                bin_reg       <= bin_next;
                pos_reg       <= pos_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (keys.valid && keys.ready)
        begin
            in_keys_reg <= keys.key_matrix;
        end
        if (step)
        begin
            out_drive_reg <= drive;
            out_pick_reg  <= pick;
            out_value_reg <= bin_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.digit_select    = out_drive_reg.select;
    assign result.segment_pattern = out_drive_reg.segment;
    assign result.key_seen        = out_pick_reg.seen;
    assign result.key_code        = out_pick_reg.code;
    assign result.shown_value     = out_value_reg;

endmodule

// ===== src/knd_keyscan.sv =====
// Finds keys that went from released to pressed and picks the last one in scan order.
// Depends on knd_pkg for the key table and the pick struct.
`timescale 1ns / 1ps

module knd_keyscan
(
    input  logic [knd_pkg::KEY_COUNT-1:0] key_matrix,
    input  logic [knd_pkg::KEY_COUNT-1:0] released,
    output logic [knd_pkg::KEY_COUNT-1:0] released_next,
    output knd_pkg::key_pick_t            pick
);

    logic [knd_pkg::KEY_COUNT-1:0] fresh;
    logic [knd_pkg::KEY_IDX_W-1:0] last_idx;

    assign fresh         = key_matrix & released;
    assign released_next = ~key_matrix;

    always_comb
    begin
        last_idx = '0;
        for (int i = 0; i < knd_pkg::KEY_COUNT; i++)
        begin
            if (fresh[i])
            begin
                last_idx = knd_pkg::KEY_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        pick.seen = |fresh;
        pick.code = pick.seen ? knd_pkg::key_code_of(last_idx) : '0;
    end

endmodule

// ===== src/knd_display.sv =====
// Drives one multiplexed digit from the held value, blanking leading zeros.
// Depends on knd_pkg for the segment table and the position codes.
`timescale 1ns / 1ps

module knd_display
(
    input  logic [knd_pkg::POS_W-1:0] position,
    input  knd_pkg::bcd_value_t       value,
    output knd_pkg::disp_drive_t      drive
);

    logic hundreds_zero;
    logic tens_zero;

    assign hundreds_zero = (value.hundreds == knd_pkg::BCD_ZERO);
    assign tens_zero     = hundreds_zero && (value.tens == knd_pkg::BCD_ZERO);

    always_comb
    begin
        case (position)
            knd_pkg::POS_TENS:
            begin
                drive.select  = knd_pkg::SEL_TENS;
                drive.segment = tens_zero ? knd_pkg::SEG_BLANK : knd_pkg::seg_of(value.tens);
            end
            knd_pkg::POS_HUNDREDS:
            begin
                drive.select  = knd_pkg::SEL_HUNDREDS;
                drive.segment = hundreds_zero ? knd_pkg::SEG_BLANK
                                              : knd_pkg::seg_of(value.hundreds);
            end
            default:
            begin
                drive.select  = knd_pkg::SEL_UNITS;
                drive.segment = knd_pkg::seg_of(value.units);
            end
        endcase
    end

endmodule

// ===== tb/keypad_number_entry_display_test.sv =====
// Self-checking testbench for keypad_number_entry_display: drives keypad snapshots and
// checks every display and key result against a tick-by-tick prediction of the block.
// Depends on knd_pkg, knd_key_if, knd_result_if and the RTL of the block.
`timescale 1ns / 1ps

module keypad_number_entry_display_test;

    localparam int SNAPSHOTS_PER_PHASE = 212;
    localparam int LONG_HOLD_CYCLES    = 40;
    localparam int REPORT_LIMIT        = 10;
    localparam int FULL_LIMIT          = 100;
    localparam int CLEAR_KEY_BIT       = 11;
    localparam int DRAIN_CYCLES        = 8;

    localparam logic [knd_pkg::CODE_W-1:0] KEY_CODES [knd_pkg::KEY_COUNT] = '{
        4'd1, 4'd2, 4'd3, 4'd10, 4'd4, 4'd5, 4'd6, 4'd11,
        4'd7, 4'd8, 4'd9, 4'd12, 4'd14, 4'd0, 4'd15, 4'd13
    };

    localparam logic [knd_pkg::SEG_W-1:0] DIGIT_SEGS [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h83, 8'hF8, 8'h80, 8'h90
    };

    // Keys are pressed one more at a time up to the full pad, then released, pressed
    // all at once, and finally nine and clear are used to reach the full value.
    localparam logic [knd_pkg::KEY_COUNT-1:0] OPENING_KEYS [26] = '{
        16'h0001, 16'h0003, 16'h0007, 16'h000F, 16'h001F, 16'h003F, 16'h007F,
        16'h00FF, 16'h01FF, 16'h03FF, 16'h07FF, 16'h0FFF, 16'h1FFF, 16'h3FFF,
        16'h7FFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0C00, 16'h0800,
        16'h0C00, 16'h0800, 16'h0C00, 16'h0800, 16'h0C00
    };

    typedef struct packed {
        logic [knd_pkg::DIGIT_COUNT-1:0] select;
        logic [knd_pkg::SEG_W-1:0]       segment;
        logic                            seen;
        logic [knd_pkg::CODE_W-1:0]      code;
        logic [knd_pkg::VALUE_W-1:0]     value;
    } tick_result_t;

    class keypad_display_board;
        logic [knd_pkg::KEY_COUNT-1:0] released_keys;
        logic [knd_pkg::VALUE_W-1:0]   entry;
        logic [knd_pkg::POS_W-1:0]     position;
        tick_result_t                  expected_ticks[$];
        int                            mismatches;

        function new();
            released_keys = '1;
            entry = '0;
            position = knd_pkg::POS_UNITS;
            mismatches = 0;
        endfunction

        function void note_keys(logic [knd_pkg::KEY_COUNT-1:0] keys);
            tick_result_t               t;
            logic [knd_pkg::POS_W-1:0]  p;
            logic [knd_pkg::CODE_W-1:0] code;
            int                         val;
            int                         place;
            bit                         seen;
            p = (position == 0 || position > knd_pkg::DIGIT_COUNT) ? knd_pkg::POS_UNITS
                                                                   : position;
            val = entry;
            place = 1;
            for (int i = 1; i < p; i++)
            begin
                place = place * 10;
            end
            case (p)
                knd_pkg::POS_UNITS: t.select = knd_pkg::SEL_UNITS;
                knd_pkg::POS_TENS:  t.select = knd_pkg::SEL_TENS;
                default:            t.select = knd_pkg::SEL_HUNDREDS;
            endcase
            if (p != knd_pkg::POS_UNITS && place > val)
            begin
                t.segment = knd_pkg::SEG_BLANK;
            end
            else
            begin
                t.segment = DIGIT_SEGS[(val / place) % 10];
            end
            position = (p == knd_pkg::POS_HUNDREDS) ? knd_pkg::POS_UNITS : p + 1'b1;
            seen = 1'b0;
            code = '0;
            for (int k = 0; k < knd_pkg::KEY_COUNT; k++)
            begin
                if (keys[k])
                begin
                    if (released_keys[k])
                    begin
                        released_keys[k] = 1'b0;
                        seen = 1'b1;
                        code = KEY_CODES[k];
                    end
                end
                else
                begin
                    released_keys[k] = 1'b1;
                end
            end
            if (seen)
            begin
                if (code == knd_pkg::CODE_CLEAR)
                begin
                    val = 0;
                end
                else if (val < FULL_LIMIT && code <= knd_pkg::CODE_LAST_DIG)
                begin
                    val = val * 10 + code;
                end
            end
            entry = knd_pkg::VALUE_W'(val);
            t.seen = seen;
            t.code = code;
            t.value = knd_pkg::VALUE_W'(val);
            expected_ticks.push_back(t);
        endfunction

        function void check_tick(tick_result_t got);
            tick_result_t exp;
            if (expected_ticks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("Unexpected result item: sel %b seg %h seen %b code %0d value %0d",
                             got.select, got.segment, got.seen, got.code, got.value);
                end
                return;
            end
            exp = expected_ticks.pop_front();
            if (got.select !== exp.select || got.segment !== exp.segment ||
                got.seen !== exp.seen || got.code !== exp.code || got.value !== exp.value)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("Mismatch: expected sel %b seg %h seen %b code %0d value %0d",
                             exp.select, exp.segment, exp.seen, exp.code, exp.value);
                    $display("          actual   sel %b seg %h seen %b code %0d value %0d",
                             got.select, got.segment, got.seen, got.code, got.value);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   stall_pct;
    bit   hold_request;

    keypad_display_board board = new();

    knd_key_if    keys_ch ();
    knd_result_if result_ch ();

    keypad_number_entry_display DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .keys   (keys_ch),
        .result (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("FAIL");
        $finish;
    end

    task automatic send_keys(input logic [knd_pkg::KEY_COUNT-1:0] snapshot);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            keys_ch.valid <= 1'b0;
            @(posedge clk);
        end
        keys_ch.valid <= 1'b1;
        keys_ch.key_matrix <= snapshot;
        do
            @(posedge clk);
        while (!keys_ch.ready);
        board.note_keys(snapshot);
    endtask

    initial
    begin
        int           hold_left;
        tick_result_t got;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.select = result_ch.digit_select;
                got.segment = result_ch.segment_pattern;
                got.seen = result_ch.key_seen;
                got.code = result_ch.key_code;
                got.value = result_ch.shown_value;
                board.check_tick(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial
    begin
        logic [knd_pkg::KEY_COUNT-1:0] held;
        logic [knd_pkg::KEY_COUNT-1:0] snapshot;
        int                            pick;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = 1'b0;
        held = '0;
        rst_n = 1'b0;
        keys_ch.valid <= 1'b0;
        keys_ch.key_matrix <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (OPENING_KEYS[i])
        begin
            send_keys(OPENING_KEYS[i]);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 81; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 7;  stall_pct = 7;  end
            endcase
            for (int n = 0; n < SNAPSHOTS_PER_PHASE; n++)
            begin
                if (phase == 0 && n == 50)
                begin
                    hold_request = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    held[$urandom_range(0, knd_pkg::KEY_COUNT - 1)] = 1'b1;
                end
                else if (pick < 65)
                begin
                    held[$urandom_range(0, knd_pkg::KEY_COUNT - 1)] = 1'b0;
                end
                else if (pick < 72)
                begin
                    held = '0;
                end
                else if (pick < 88)
                begin
                    held[CLEAR_KEY_BIT] = ~held[CLEAR_KEY_BIT];
                end
                else
                begin
                    held = knd_pkg::KEY_COUNT'($urandom);
                end
                snapshot = held;
                send_keys(snapshot);
            end
        end
        keys_ch.valid <= 1'b0;

        while (board.expected_ticks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.expected_ticks.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
